// ===== design/dbc_pkg.sv =====
// ============================================================================
// dbc_pkg: DES block cipher shared definitions
// Permutation tables, S-boxes, key schedule helpers and stage types.
// ============================================================================
package dbc_pkg;

    localparam int unsigned BLOCK_W  = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned CD_W     = 56;
    localparam int unsigned C_W      = 28;
    localparam int unsigned SUBKEY_W = 48;
    localparam int unsigned NROUNDS  = 16;

    // action codes
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    // data carried from one round cell to the next
    typedef struct packed {
        logic             valid;
        logic             decrypt;
        logic [C_W-1:0]   c;
        logic [C_W-1:0]   d;
        logic [HALF_W-1:0] l;
        logic [HALF_W-1:0] r;
    } stage_t;

    typedef logic [7:0] tab_idx_t;

    // Initial permutation (1-based source bit, MSB first)
    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        tab_idx_t t [64];
        logic [63:0] y;
        t = '{8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,
              8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
              8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,
              8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
              8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,
              8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
              8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,
              8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};
        for (int i = 0; i < 64; i++)
            y[63-i] = x[64 - int'(t[i])];
        return y;
    endfunction

    // Final permutation
    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        tab_idx_t t [64];
        logic [63:0] y;
        t = '{8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32,
              8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
              8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30,
              8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
              8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28,
              8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
              8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26,
              8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};
        for (int i = 0; i < 64; i++)
            y[63-i] = x[64 - int'(t[i])];
        return y;
    endfunction

    // Expansion 32 -> 48
    function automatic logic [47:0] perm_e(input logic [31:0] x);
        tab_idx_t t [48];
        logic [47:0] y;
        t = '{8'd32,8'd1,8'd2,8'd3,8'd4,8'd5,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
              8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
              8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
              8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};
        for (int i = 0; i < 48; i++)
            y[47-i] = x[32 - int'(t[i])];
        return y;
    endfunction

    // P permutation
    function automatic logic [31:0] perm_p(input logic [31:0] x);
        tab_idx_t t [32];
        logic [31:0] y;
        t = '{8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17,
              8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
              8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,
              8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};
        for (int i = 0; i < 32; i++)
            y[31-i] = x[32 - int'(t[i])];
        return y;
    endfunction

    // PC-1 64 -> 56
    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        tab_idx_t t [56];
        logic [55:0] y;
        t = '{8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd58,8'd50,8'd42,8'd34,
              8'd26,8'd18,8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
              8'd60,8'd52,8'd44,8'd36,8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7,
              8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,
              8'd29,8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};
        for (int i = 0; i < 56; i++)
            y[55-i] = x[64 - int'(t[i])];
        return y;
    endfunction

    // PC-2 56 -> 48
    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        tab_idx_t t [48];
        logic [47:0] y;
        t = '{8'd14,8'd17,8'd11,8'd24,8'd1,8'd5,8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
              8'd23,8'd19,8'd12,8'd4,8'd26,8'd8,8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
              8'd41,8'd52,8'd31,8'd37,8'd47,8'd55,8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
              8'd44,8'd49,8'd39,8'd56,8'd34,8'd53,8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};
        for (int i = 0; i < 48; i++)
            y[47-i] = x[56 - int'(t[i])];
        return y;
    endfunction

    // Per-round shift amount: one for rounds 1, 2, 9, 16, else two
    function automatic logic rot_one(input int unsigned k);
        return (k == 0) || (k == 1) || (k == 8) || (k == 15);
    endfunction

    function automatic logic [27:0] rol28(input logic [27:0] x, input logic one);
        return one ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
    endfunction

    function automatic logic [27:0] ror28(input logic [27:0] x, input logic one);
        return one ? {x[0], x[27:1]} : {x[1:0], x[27:2]};
    endfunction

    // S-box lookup: box n, 6-bit input
    function automatic logic [3:0] sbox(input logic [2:0] n, input logic [5:0] b);
        logic [3:0] s [8][64];
        logic [5:0] idx;
        s[0] = '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
                 4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
                 4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
                 4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13};
        s[1] = '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
                 4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
                 4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
                 4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9};
        s[2] = '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
                 4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
                 4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
                 4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12};
        s[3] = '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
                 4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
                 4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
                 4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14};
        s[4] = '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
                 4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
                 4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
                 4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3};
        s[5] = '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
                 4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
                 4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
                 4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13};
        s[6] = '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
                 4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
                 4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
                 4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12};
        s[7] = '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
                 4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
                 4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
                 4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11};
        idx = {b[5], b[0], b[4:1]};
        return s[n][idx];
    endfunction

    // Feistel function
    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] o;
        x = perm_e(r) ^ k;
        for (int i = 0; i < 8; i++)
            o[31-4*i -: 4] = sbox(3'(i), x[47-6*i -: 6]);
        return perm_p(o);
    endfunction

endpackage

// ===== design/des_block_cipher_unit.sv =====
// ============================================================================
// des_block_cipher_unit: pipelined DES encrypt/decrypt
// Sixteen round cells in a row, with an input permutation and an output
// register stage; one block per cycle while the output is accepted.
// ============================================================================
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid / tready  | tdata = data_in[63:0], tuser = action
//  m_axis  | out | tvalid / tready  | tdata = data_out[63:0]
//  cfg     | in  | cfg_we           | cfg_wdata = cipher_key[63:0]
//
// Eighteen register stages (input stage, 16 round cells, output stage): a
// result passes through each of them in order before it shows on m_axis;
// one transaction is taken every cycle while the output is accepted.
// The whole pipeline advances together; a stall on m_axis_tready holds every
// stage, and s_axis_tready follows it: the row moves whenever the output
// register is empty or being taken.
// Reset clears the key to zero and all stage valid flags.
module des_block_cipher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,       // cipher_key
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,    // [63:0] data_in
    input  logic        s_axis_tuser,    // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata     // [63:0] data_out
);

    logic [63:0]     key_reg;
    logic            advance;
    dbc_pkg::stage_t chain [dbc_pkg::NROUNDS+1];
    dbc_pkg::stage_t in_reg;
    logic            out_valid_reg;
    logic [63:0]     out_data_reg;
    logic [55:0]     cd;
    logic [63:0]     ip_blk;
    logic [63:0]     fp_blk;

    // Key register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '0;
        else if (cfg_we)
            key_reg <= cfg_wdata;
    end

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // Input stage: initial permutation and PC-1
    assign cd     = dbc_pkg::perm_pc1(key_reg);
    assign ip_blk = dbc_pkg::perm_ip(s_axis_tdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_reg.valid <= 1'b0;
        else if (advance)
        begin
            in_reg.valid   <= s_axis_tvalid;
            in_reg.decrypt <= s_axis_tuser;
            in_reg.c       <= cd[55:28];
            in_reg.d       <= cd[27:0];
            in_reg.l       <= ip_blk[63:32];
            in_reg.r       <= ip_blk[31:0];
        end
    end

    assign chain[0] = in_reg;

    // Row of round cells
    for (genvar g = 0; g < dbc_pkg::NROUNDS; g++)
    begin : g_round
        dbc_round_cell #(.ROUND_IDX(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .stage_in  (chain[g]),
            .stage_out (chain[g+1])
        );
    end

    // Output stage: swap halves and final permutation
    assign fp_blk = dbc_pkg::perm_fp({chain[dbc_pkg::NROUNDS].r, chain[dbc_pkg::NROUNDS].l});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain[dbc_pkg::NROUNDS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= fp_blk;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== design/dbc_round_cell.sv =====
// ============================================================================
// dbc_round_cell: one DES round
// Advances the key halves for its round, applies one Feistel round and
// registers the result for the next cell.
// ============================================================================
module dbc_round_cell #(
    parameter int unsigned ROUND_IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  dbc_pkg::stage_t  stage_in,
    output dbc_pkg::stage_t  stage_out
);

    localparam logic ROT_ONE = dbc_pkg::rot_one(ROUND_IDX);
    // decrypt undoes the shift of the reverse round; its rotation is applied after use
    localparam logic DEC_ONE = dbc_pkg::rot_one(dbc_pkg::NROUNDS - 1 - ROUND_IDX);

    dbc_pkg::stage_t stage_reg;
    dbc_pkg::stage_t stage_next;
    logic [27:0] c_use;
    logic [27:0] d_use;
    logic [47:0] subkey;

    // Encrypt rotates left before use; decrypt uses the key then rotates right
    always_comb
    begin
        if (stage_in.decrypt)
        begin
            c_use = stage_in.c;
            d_use = stage_in.d;
        end
        else
        begin
            c_use = dbc_pkg::rol28(stage_in.c, ROT_ONE);
            d_use = dbc_pkg::rol28(stage_in.d, ROT_ONE);
        end
        subkey = dbc_pkg::perm_pc2({c_use, d_use});
        stage_next         = stage_in;
        stage_next.l       = stage_in.r;
        stage_next.r       = stage_in.l ^ dbc_pkg::feistel(stage_in.r, subkey);
        if (stage_in.decrypt)
        begin
            stage_next.c = dbc_pkg::ror28(c_use, DEC_ONE);
            stage_next.d = dbc_pkg::ror28(d_use, DEC_ONE);
        end
        else
        begin
            stage_next.c = c_use;
            stage_next.d = d_use;
        end
    end

    // Stage register, held while the pipeline stalls; only valid is reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg.valid <= 1'b0;
        else if (advance)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

// ===== design/dbc_checker.sv =====
// ============================================================================
// dbc_checker: port-level checks for the DES unit
// Watches the stream handshakes and the output valid after reset.
// ============================================================================
module dbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // A stalled result holds its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Input is ready whenever the output is not held
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // Ready drops while the output is stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken during output stall");

    // No result is valid right after reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result right after reset");

endmodule

bind des_block_cipher_unit dbc_checker u_dbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/des_block_cipher_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// des_block_cipher_unit_tb: DES cipher unit stream test
// Sends blocks to encrypt or decrypt under a run of keys, predicts each
// output block with an independent DES model, and compares in order.
// ============================================================================

// Holds the predicted output blocks and checks the ones that come back
class des_scoreboard;
    logic [63:0] pending_blocks [$];
    int          n_errors;
    logic [63:0] cur_key;

    // S-boxes, flattened row-major: box n entry i at n*64+i
    static logic [3:0] sbox_rom [512] = '{
        14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13,
        15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9,
        10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12,
        7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14,
        2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3,
        12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13,
        4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12,
        13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11};

    static byte ip_map [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4, 62,54,46,38,30,22,14,6,
        64,56,48,40,32,24,16,8, 57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    static byte fp_map [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31, 38,6,46,14,54,22,62,30,
        37,5,45,13,53,21,61,29, 36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    static byte e_map [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    static byte p_map [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    static byte pc1_map [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
        19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    static byte pc2_map [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
    static byte shift_sched [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    function new();
        n_errors = 0;
        cur_key  = '0;
    endfunction

    // Gather bits: output bit i (MSB first) takes source bit map[i] of a w-bit word
    static function logic [63:0] gather(logic [63:0] x, int w, byte map [], int n);
        logic [63:0] y;
        y = '0;
        for (int i = 0; i < n; i++)
            y = {y[62:0], x[w - map[i]]};
        return y;
    endfunction

    static function logic [31:0] round_fn(logic [31:0] r, logic [47:0] k);
        logic [47:0] x;
        logic [31:0] o;
        logic [5:0]  b;
        x = 48'(gather({32'b0, r}, 32, e_map, 48)) ^ k;
        o = '0;
        for (int i = 0; i < 8; i++)
        begin
            b = x[47-6*i -: 6];
            o = {o[27:0], sbox_rom[i*64 + {b[5], b[0], b[4:1]}]};
        end
        return 32'(gather({32'b0, o}, 32, p_map, 32));
    endfunction

    static function logic [63:0] des_block(logic [63:0] key, logic dec, logic [63:0] blk);
        logic [47:0] sk [16];
        logic [55:0] cd;
        logic [27:0] c, d;
        logic [63:0] t;
        logic [31:0] l, r, tmp;
        cd = 56'(gather(key, 64, pc1_map, 56));
        c = cd[55:28];
        d = cd[27:0];
        for (int k = 0; k < 16; k++)
        begin
            repeat (shift_sched[k])
            begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            sk[k] = 48'(gather({8'b0, c, d}, 56, pc2_map, 48));
        end
        t = gather(blk, 64, ip_map, 64);
        l = t[63:32];
        r = t[31:0];
        for (int k = 0; k < 16; k++)
        begin
            tmp = l ^ round_fn(r, sk[dec ? 15 - k : k]);
            l = r;
            r = tmp;
        end
        return gather({r, l}, 64, fp_map, 64);
    endfunction

    function void note_block(logic dec, logic [63:0] blk);
        pending_blocks.push_back(des_block(cur_key, dec, blk));
    endfunction

    function void check_block(logic [63:0] got);
        logic [63:0] want;
        if (pending_blocks.size() == 0)
        begin
            $error("unexpected transaction: data_out actual %h", got);
            n_errors++;
            return;
        end
        want = pending_blocks.pop_front();
        if (want !== got)
        begin
            $error("data_out mismatch: expected %h actual %h", want, got);
            n_errors++;
        end
    endfunction
endclass

module des_block_cipher_unit_tb;

    localparam int PIPE_LAT = 18;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [63:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    des_scoreboard sb;
    bit            long_hold_req;
    bit            long_hold_done;

    des_block_cipher_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Drop the input offer after the last transaction
    task automatic stop_input();
        s_axis_tvalid <= 1'b0;
    endtask

    // Offer one block and wait for its transaction; valid stays up for the next
    task automatic send_block(logic dec, logic [63:0] blk, bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= dec;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_block(dec, blk);
    endtask

    // Wait for the pipeline to drain, then change the key
    task automatic load_key(logic [63:0] key);
        stop_input();
        while (sb.pending_blocks.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= key;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.cur_key = key;
        @(posedge clk);
    endtask

    // Random block with occasional all-zero/all-one runs
    function automatic logic [63:0] rand_block();
        int p;
        p = $urandom_range(19);
        if (p == 0)
            return '0;
        else if (p == 1)
            return '1;
        return {$urandom(), $urandom()};
    endfunction

    // Output side: random stalls plus one long hold on request
    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge clk);
                long_hold_done = 1'b1;
            end
            g = gap_len();
            if (g == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat (g - 1) @(posedge clk);
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_block(m_axis_tdata);
    end

    // Stimulus
    initial
    begin
        logic [63:0] keys [6];
        logic [63:0] pt;
        sb = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = dbc_pkg::ACT_ENCRYPT;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key (zero), field extremes, both actions
        send_block(dbc_pkg::ACT_ENCRYPT, '0, 0);
        send_block(dbc_pkg::ACT_ENCRYPT, '1, 0);
        send_block(dbc_pkg::ACT_DECRYPT, '0, 0);
        send_block(dbc_pkg::ACT_DECRYPT, '1, 0);

        // Standard vector, then two weak keys and a key with bad parity
        load_key(64'h133457799BBCDFF1);
        send_block(dbc_pkg::ACT_ENCRYPT, 64'h0123456789ABCDEF, 0);
        send_block(dbc_pkg::ACT_DECRYPT, 64'h85E813540F0AB405, 0);
        send_block(dbc_pkg::ACT_ENCRYPT, 64'h8000000000000001, 0);
        load_key(64'h0101010101010101);
        send_block(dbc_pkg::ACT_ENCRYPT, 64'h5555AAAA5555AAAA, 0);
        send_block(dbc_pkg::ACT_DECRYPT, 64'hAAAA5555AAAA5555, 0);
        load_key(64'h0000000000000000 | 64'hFEFEFEFEFEFEFEFE);
        send_block(dbc_pkg::ACT_ENCRYPT, 64'h0123456789ABCDEF, 0);
        load_key(64'hFFFFFFFFFFFFFFFF);
        send_block(dbc_pkg::ACT_DECRYPT, '1, 0);
        send_block(dbc_pkg::ACT_ENCRYPT, '0, 0);

        // Random phases under several keys, with random actions and blocks
        keys = '{64'h0, 64'hFFFFFFFFFFFFFFFF, {$urandom(), $urandom()},
                 {$urandom(), $urandom()}, 64'h0123456789ABCDEF, {$urandom(), $urandom()}};
        for (int ph = 0; ph < 6; ph++)
        begin
            load_key(keys[ph]);
            if (ph == 2)
                long_hold_req = 1'b1;
            for (int n = 0; n < 200; n++)
            begin
                pt = rand_block();
                send_block(logic'($urandom_range(1)), pt, (ph != 4) && (n % 50 > 10));
                // sender waits for the pipeline to empty once mid-phase
                if (ph == 3 && n == 100)
                begin
                    stop_input();
                    while (sb.pending_blocks.size() != 0)
                        @(posedge clk);
                end
            end
        end

        stop_input();
        while (sb.pending_blocks.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
        if (sb.n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
